// ===== design/fvp_pkg.sv =====
// shared constants, types and sine quarter-wave table for the foc voltage modulator
package fvp_pkg;

    localparam int ANGLE_BITS      = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
    localparam int QTR_SIZE        = 1 << QTR_BITS;
    localparam logic [QTR_BITS:0] QTR_FULL = (QTR_BITS + 1)'(QTR_SIZE);

    localparam int SIN_W  = 16;
    localparam int SIN_SW = SIN_W + 1;
    localparam int VOLT_W = 16;

    localparam int PP_W     = 7;
    localparam int SUPPLY_W = 14;
    localparam int LIMIT_W  = 14;
    localparam int PERIOD_W = 16;
    localparam int CMP_W    = 16;
    localparam int NUM_PH   = 3;

    localparam int PROD_W = VOLT_W + SIN_SW;
    localparam int AB_W   = PROD_W + 1;
    localparam int K_W    = 18;
    localparam logic signed [K_W-1:0] SQRT3_Q16 = 18'sd113512;
    localparam int M_W    = AB_W + K_W;
    localparam int PH_W   = M_W + 2;

    localparam int ALPHA_SH  = 16;
    localparam int OFFS_SH   = 31;
    localparam int CAP_SH    = 32;
    localparam int D_W       = LIMIT_W + CAP_SH;
    localparam int DL_W      = CAP_SH;
    localparam int DH_W      = LIMIT_W;
    localparam int HP_W      = DH_W + PERIOD_W;
    localparam int LP_W      = DL_W + PERIOD_W;
    localparam int NS_W      = LP_W + 1;
    localparam int NHI_W     = HP_W + 1;
    localparam int QUOT_BITS = CMP_W;
    localparam int REM_W     = SUPPLY_W + QUOT_BITS;

    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POLE_CNT,
        REG_SUPPLY,
        REG_LIMIT,
        REG_PERIOD
    } t_reg_idx;

    typedef struct packed {
        logic [PP_W-1:0]     pole_cnt;
        logic [SUPPLY_W-1:0] supply_voltage;
        logic [LIMIT_W-1:0]  volt_cap;
        logic [PERIOD_W-1:0] pwm_top;
    } t_cfg;

    localparam t_cfg CFG_RST = '{
        pole_cnt:       PP_W'(7),
        supply_voltage: SUPPLY_W'(3072),
        volt_cap:       LIMIT_W'(3072),
        pwm_top:        PERIOD_W'(1280)
    };

    typedef struct packed {
        logic signed [SIN_SW-1:0] sn;
        logic signed [SIN_SW-1:0] cs;
        logic signed [VOLT_W-1:0] uq;
        logic signed [VOLT_W-1:0] ud;
    } t_rot_beat;

    typedef struct packed {
        logic [NUM_PH-1:0][DH_W-1:0] dh;
        logic [NUM_PH-1:0][DL_W-1:0] dl;
    } t_clamp_beat;

    // quarter-wave polynomial, q30 arithmetic
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] SIN_C1  = 64'd1686629713;
    localparam logic [63:0] SIN_C3  = 64'd693598672;
    localparam logic [63:0] SIN_C5  = 64'd85569306;
    localparam logic [63:0] SIN_C7  = 64'd5026995;
    localparam logic [63:0] SIN_C9  = 64'd172272;

    typedef logic [QTR_SIZE-1:0][SIN_W-1:0] t_qsin_tab;

    function automatic logic [63:0] qsin_calc(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((p * x2) >> 30);
        p  = SIN_C5 - ((p * x2) >> 30);
        p  = SIN_C3 - ((p * x2) >> 30);
        p  = SIN_C1 - ((p * x2) >> 30);
        s  = (p * x) >> 30;
        if (s > Q30_ONE) begin
            s = Q30_ONE;
        end
        return (s + 64'd16384) >> 15;
    endfunction

    function automatic t_qsin_tab qsin_build();
        t_qsin_tab tab;
        for (int i = 0; i < QTR_SIZE; i++) begin
            tab[i] = SIN_W'(qsin_calc(64'(i) << (32 - SINE_TABLE_BITS)));
        end
        return tab;
    endfunction

    localparam t_qsin_tab        QSIN_TAB = qsin_build();
    localparam logic [SIN_W-1:0] QSIN_TOP = SIN_W'(qsin_calc(Q30_ONE));

endpackage

// ===== design/fvp_if.sv =====
// valid/ready channel interfaces for command and compare beats
interface fvp_cmd_if import fvp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ANGLE_BITS-1:0]    mech_angle;
    logic signed [VOLT_W-1:0] volt_q;
    logic signed [VOLT_W-1:0] volt_d;

    modport source (output valid, mech_angle, volt_q, volt_d, input ready);
    modport sink   (input valid, mech_angle, volt_q, volt_d, output ready);
endinterface

interface fvp_pwm_if import fvp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMP_W-1:0] compare_a;
    logic [CMP_W-1:0] compare_b;
    logic [CMP_W-1:0] compare_c;

    modport source (output valid, compare_a, compare_b, compare_c, input ready);
    modport sink   (input valid, compare_a, compare_b, compare_c, output ready);
endinterface

// ===== design/fvp_regs.sv =====
// apb configuration registers
module fvp_regs import fvp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output logic [PDATA_W-1:0] o_prdata,
    output logic               o_pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx sel;
    logic     wr;

    assign sel      = t_reg_idx'(i_paddr[PADDR_W-1:2]);
    assign wr       = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr) begin
            unique case (sel)
                REG_POLE_CNT: n_cfg.pole_cnt       = i_pwdata[PP_W-1:0];
                REG_SUPPLY:   n_cfg.supply_voltage = i_pwdata[SUPPLY_W-1:0];
                REG_LIMIT:    n_cfg.volt_cap       = i_pwdata[LIMIT_W-1:0];
                REG_PERIOD:   n_cfg.pwm_top        = i_pwdata[PERIOD_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_POLE_CNT: o_prdata = PDATA_W'(r_cfg.pole_cnt);
            REG_SUPPLY:   o_prdata = PDATA_W'(r_cfg.supply_voltage);
            REG_LIMIT:    o_prdata = PDATA_W'(r_cfg.volt_cap);
            REG_PERIOD:   o_prdata = PDATA_W'(r_cfg.pwm_top);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== design/fvp_sincos.sv =====
// electrical angle and sine/cosine lookup, two stages
module fvp_sincos import fvp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [ANGLE_BITS-1:0]    i_mech_angle,
    input  logic signed [VOLT_W-1:0] i_volt_q,
    input  logic signed [VOLT_W-1:0] i_volt_d,
    input  logic [PP_W-1:0]          i_pole_cnt,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_rot_beat                o_beat
);

    localparam int N = 2;
    localparam logic signed [SIN_SW-1:0] SIN_PEAK = $signed({1'b0, QSIN_TOP});

    logic [N-1:0] r_v;
    logic [N-1:0] adv;

    logic [SINE_TABLE_BITS-1:0] r_idx;
    logic [SINE_TABLE_BITS-1:0] n_idx;
    logic signed [VOLT_W-1:0]   r_uq;
    logic signed [VOLT_W-1:0]   r_ud;
    t_rot_beat                  r_beat;
    t_rot_beat                  n_beat;

    logic [ANGLE_BITS+PP_W-1:0]            prod;
    logic [ANGLE_BITS+SINE_TABLE_BITS-1:0] wide;

    function automatic logic signed [SIN_SW-1:0] rom_sine(
        input logic [SINE_TABLE_BITS-1:0] idx
    );
        logic [QTR_BITS:0] q;
        logic [SIN_W-1:0]  mag;
        if (idx[SINE_TABLE_BITS-2]) begin
            q = QTR_FULL - {1'b0, idx[QTR_BITS-1:0]};
        end else begin
            q = {1'b0, idx[QTR_BITS-1:0]};
        end
        mag = q[QTR_BITS] ? QSIN_TOP : QSIN_TAB[q[QTR_BITS-1:0]];
        if (idx[SINE_TABLE_BITS-1]) begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

    for (genvar k = 0; k < N; k++) begin : g_adv
        assign adv[k] = i_ready || !(&r_v[N-1:k]);
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[N-1];
    assign o_beat  = r_beat;

    // electrical angle wraps modulo one turn
    always_comb begin
        prod  = i_mech_angle * i_pole_cnt;
        wide  = {prod[ANGLE_BITS-1:0], {SINE_TABLE_BITS{1'b0}}};
        n_idx = wide[ANGLE_BITS+SINE_TABLE_BITS-1 -: SINE_TABLE_BITS];
    end

    always_comb begin
        n_beat.sn = rom_sine(r_idx);
        n_beat.cs = rom_sine(r_idx + SINE_TABLE_BITS'(QTR_SIZE));
        n_beat.uq = r_uq;
        n_beat.ud = r_ud;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_idx <= n_idx;
            r_uq  <= i_volt_q;
            r_ud  <= i_volt_d;
        end
        if (adv[1]) begin
            r_beat <= n_beat;
        end
    end

    a_sin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_beat.sn <= SIN_PEAK) && (r_beat.sn >= -SIN_PEAK)
                 && (r_beat.cs <= SIN_PEAK) && (r_beat.cs >= -SIN_PEAK))
        else $error("sine or cosine out of range");

    a_sin_cos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_beat.sn != '0) || (r_beat.cs != '0))
        else $error("sine and cosine both zero");

endmodule

// ===== design/fvp_xform.sv =====
// inverse park and clarke with supply offset and clamp, five stages
module fvp_xform import fvp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_rot_beat           i_beat,
    input  logic [SUPPLY_W-1:0] i_supply,
    input  logic [LIMIT_W-1:0]  i_limit,
    output logic                o_valid,
    input  logic                i_ready,
    output t_clamp_beat         o_beat
);

    localparam int N = 5;

    logic [N-1:0] r_v;
    logic [N-1:0] adv;

    logic signed [PROD_W-1:0] r_pdc, r_pqs, r_pqc, r_pds;
    logic signed [PROD_W-1:0] n_pdc, n_pqs, n_pqc, n_pds;
    logic signed [AB_W-1:0]   r_alpha1, r_beta, r_alpha2;
    logic signed [AB_W-1:0]   n_alpha1, n_beta;
    logic signed [M_W-1:0]    r_m, n_m;
    logic signed [PH_W-1:0]   r_ph [NUM_PH];
    logic signed [PH_W-1:0]   n_ph [NUM_PH];
    t_clamp_beat              r_clamp, n_clamp;

    logic signed [PH_W-1:0]   offs;
    logic signed [PH_W-1:0]   alpha_x;
    logic signed [PH_W-1:0]   m_x;
    logic [LIMIT_W-1:0]       cap;
    logic [D_W-1:0]           cap_w;
    logic [D_W-1:0]           d;

    for (genvar k = 0; k < N; k++) begin : g_adv
        assign adv[k] = i_ready || !(&r_v[N-1:k]);
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[N-1];
    assign o_beat  = r_clamp;

    always_comb begin
        n_pdc = i_beat.ud * i_beat.cs;
        n_pqs = i_beat.uq * i_beat.sn;
        n_pqc = i_beat.uq * i_beat.cs;
        n_pds = i_beat.ud * i_beat.sn;
    end

    always_comb begin
        n_alpha1 = AB_W'(r_pdc) - AB_W'(r_pqs);
        n_beta   = AB_W'(r_pqc) + AB_W'(r_pds);
        n_m      = r_beta * SQRT3_Q16;
    end

    // doubled phase voltages plus half supply
    always_comb begin
        offs    = $signed(PH_W'(i_supply) << OFFS_SH);
        alpha_x = PH_W'(r_alpha2);
        m_x     = PH_W'(r_m);
        n_ph[0] = (alpha_x <<< (ALPHA_SH + 1)) + offs;
        n_ph[1] = m_x - (alpha_x <<< ALPHA_SH) + offs;
        n_ph[2] = offs - (alpha_x <<< ALPHA_SH) - m_x;
    end

    always_comb begin
        cap   = (i_limit < i_supply) ? i_limit : LIMIT_W'(i_supply);
        cap_w = D_W'(cap) << CAP_SH;
        d     = '0;
        n_clamp = '0;
        for (int l = 0; l < NUM_PH; l++) begin
            if (r_ph[l][PH_W-1]) begin
                d = '0;
            end else if ($unsigned(r_ph[l]) > PH_W'(cap_w)) begin
                d = cap_w;
            end else begin
                d = D_W'(r_ph[l]);
            end
            n_clamp.dh[l] = d[D_W-1:DL_W];
            n_clamp.dl[l] = d[DL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_pdc <= n_pdc;
            r_pqs <= n_pqs;
            r_pqc <= n_pqc;
            r_pds <= n_pds;
        end
        if (adv[1]) begin
            r_alpha1 <= n_alpha1;
            r_beta   <= n_beta;
        end
        if (adv[2]) begin
            r_alpha2 <= r_alpha1;
            r_m      <= n_m;
        end
        if (adv[3]) begin
            r_ph <= n_ph;
        end
        if (adv[4]) begin
            r_clamp <= n_clamp;
        end
    end

endmodule

// ===== design/fvp_duty.sv =====
// duty scaling and pipelined restoring divide by supply, three lanes
module fvp_duty import fvp_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  t_clamp_beat                  i_beat,
    input  logic [SUPPLY_W-1:0]          i_supply,
    input  logic [PERIOD_W-1:0]          i_period,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [NUM_PH-1:0][CMP_W-1:0] o_cmp
);

    localparam int N = QUOT_BITS + 2;

    logic [N-1:0] r_v;
    logic [N-1:0] adv;

    logic [HP_W-1:0]  r_hp [NUM_PH];
    logic [HP_W-1:0]  n_hp [NUM_PH];
    logic [LP_W-1:0]  r_lp [NUM_PH];
    logic [LP_W-1:0]  n_lp [NUM_PH];
    logic [REM_W-1:0] r_rem [QUOT_BITS+1][NUM_PH];
    logic [REM_W-1:0] n_rem [QUOT_BITS+1][NUM_PH];
    logic [CMP_W-1:0] r_q   [QUOT_BITS+1][NUM_PH];
    logic [CMP_W-1:0] n_q   [QUOT_BITS+1][NUM_PH];

    logic [NS_W-1:0]  nsum  [NUM_PH];
    logic [NHI_W-1:0] nhi   [NUM_PH];
    logic [REM_W-1:0] ds    [QUOT_BITS];

    for (genvar k = 0; k < N; k++) begin : g_adv
        assign adv[k] = i_ready || !(&r_v[N-1:k]);
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[N-1];

    always_comb begin
        for (int l = 0; l < NUM_PH; l++) begin
            o_cmp[l] = r_q[QUOT_BITS][l];
        end
    end

    // split product keeps each multiplier within 32 by 16
    always_comb begin
        for (int l = 0; l < NUM_PH; l++) begin
            n_hp[l] = i_beat.dh[l] * i_period;
            n_lp[l] = i_beat.dl[l] * i_period;
        end
    end

    always_comb begin
        // top bits of duty times period plus half of the denominator
        for (int l = 0; l < NUM_PH; l++) begin
            nsum[l]     = NS_W'(r_lp[l]) + (NS_W'(i_supply) << (CAP_SH - 1));
            nhi[l]      = NHI_W'(r_hp[l]) + NHI_W'(nsum[l][NS_W-1:CAP_SH]);
            n_rem[0][l] = nhi[l][REM_W-1:0];
            n_q[0][l]   = '0;
        end
        // one quotient bit per stage
        for (int s = 0; s < QUOT_BITS; s++) begin
            ds[s] = REM_W'(i_supply) << (QUOT_BITS - 1 - s);
            for (int l = 0; l < NUM_PH; l++) begin
                if (r_rem[s][l] >= ds[s]) begin
                    n_rem[s+1][l] = r_rem[s][l] - ds[s];
                    n_q[s+1][l]   = r_q[s][l] | (CMP_W'(1) << (QUOT_BITS - 1 - s));
                end else begin
                    n_rem[s+1][l] = r_rem[s][l];
                    n_q[s+1][l]   = r_q[s][l];
                end
                if ((s == QUOT_BITS - 1) && (i_supply == '0)) begin
                    n_q[s+1][l] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < N; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_hp <= n_hp;
            r_lp <= n_lp;
        end
        for (int s = 0; s <= QUOT_BITS; s++) begin
            if (adv[s+1]) begin
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
            end
        end
    end

    a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] |-> (r_q[1][0][QUOT_BITS-2:0] == '0) && (r_q[1][1][QUOT_BITS-2:0] == '0)
                && (r_q[1][2][QUOT_BITS-2:0] == '0))
        else $error("undecided quotient bits set after first divide stage");

    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv[2] && r_v[1]) |=> (r_rem[1][0] <= $past(r_rem[0][0]))
                            && (r_rem[1][1] <= $past(r_rem[0][1]))
                            && (r_rem[1][2] <= $past(r_rem[0][2])))
        else $error("divide stage grew the remainder");

endmodule

// ===== design/foc_voltage_to_pwm.sv =====
// foc voltage modulator top level: angle, inverse park/clarke, sine pwm compares
//
//  channel   dir  handshake               payload
//  i_cmd     in   valid/ready             mech_angle, volt_q, volt_d
//  o_pwm     out  valid/ready             compare_a, compare_b, compare_c
//  apb       in   psel/penable/pwrite     paddr, pwdata -> prdata, pready
//
//  one beat per cycle unless o_pwm stalls; 2 angle/sine, 5 transform, 18 duty stages
//  the duty stages are set by the one-bit-per-stage divide by supply_voltage
//  reset clears all stage valid bits and loads the register defaults
//  an o_pwm stall holds only occupied stages, empty stages keep filling
module foc_voltage_to_pwm import fvp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fvp_cmd_if.sink            i_cmd,
    fvp_pwm_if.source          o_pwm,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg        cfg;
    logic        rot_valid, rot_ready;
    t_rot_beat   rot_beat;
    logic        clp_valid, clp_ready;
    t_clamp_beat clp_beat;
    logic [NUM_PH-1:0][CMP_W-1:0] cmp;

    fvp_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    fvp_sincos u_sincos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_cmd.valid),
        .o_ready      (i_cmd.ready),
        .i_mech_angle (i_cmd.mech_angle),
        .i_volt_q     (i_cmd.volt_q),
        .i_volt_d     (i_cmd.volt_d),
        .i_pole_cnt   (cfg.pole_cnt),
        .o_valid      (rot_valid),
        .i_ready      (rot_ready),
        .o_beat       (rot_beat)
    );

    fvp_xform u_xform (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (rot_valid),
        .o_ready  (rot_ready),
        .i_beat   (rot_beat),
        .i_supply (cfg.supply_voltage),
        .i_limit  (cfg.volt_cap),
        .o_valid  (clp_valid),
        .i_ready  (clp_ready),
        .o_beat   (clp_beat)
    );

    fvp_duty u_duty (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (clp_valid),
        .o_ready  (clp_ready),
        .i_beat   (clp_beat),
        .i_supply (cfg.supply_voltage),
        .i_period (cfg.pwm_top),
        .o_valid  (o_pwm.valid),
        .i_ready  (o_pwm.ready),
        .o_cmp    (cmp)
    );

    assign o_pwm.compare_a = cmp[0];
    assign o_pwm.compare_b = cmp[1];
    assign o_pwm.compare_c = cmp[2];

endmodule

// ===== tb/tb_foc_voltage_to_pwm.sv =====
// self-checking testbench for the foc voltage modulator: random beats, stalls and apb settings
module tb_foc_voltage_to_pwm;
    import fvp_pkg::*;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]    mech_angle;
        logic signed [VOLT_W-1:0] volt_q;
        logic signed [VOLT_W-1:0] volt_d;
    } t_cmd;

    typedef struct packed {
        logic [CMP_W-1:0] compare_a;
        logic [CMP_W-1:0] compare_b;
        logic [CMP_W-1:0] compare_c;
    } t_compares;

    localparam longint unsigned Q30 = 64'd1073741824;
    localparam longint unsigned K1  = 64'd1686629713;
    localparam longint unsigned K3  = 64'd693598672;
    localparam longint unsigned K5  = 64'd85569306;
    localparam longint unsigned K7  = 64'd5026995;
    localparam longint unsigned K9  = 64'd172272;
    localparam longint ROOT3_Q16    = 113512;
    localparam int QUARTER_TURN     = 1 << (SINE_TABLE_BITS - 2);

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    fvp_cmd_if cmd();
    fvp_pwm_if pwm();

    foc_voltage_to_pwm DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_pwm   (pwm),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [PP_W-1:0]     cfg_pp     = 7;
    logic [SUPPLY_W-1:0] cfg_supply = 3072;
    logic [LIMIT_W-1:0]  cfg_limit  = 3072;
    logic [PERIOD_W-1:0] cfg_period = 1280;

    t_cmd      cmd_backlog[$];
    t_compares expected_compares[$];
    t_cmd      sent_cmd;
    int        awaited_results = 0;
    int        failures = 0;
    int        burst_left = 1;
    int        idle_left = 0;
    logic [15:0] stall_pat = '1;
    logic [3:0]  stall_pos = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint sine_q15(input int unsigned idx);
        logic [SINE_TABLE_BITS-1:0] slot;
        logic [1:0] quad;
        longint unsigned x, x2, poly, s;
        slot = SINE_TABLE_BITS'(idx);
        quad = slot[SINE_TABLE_BITS-1 -: 2];
        x = 64'(slot[SINE_TABLE_BITS-3:0]) << (32 - SINE_TABLE_BITS);
        if (quad[0]) begin
            x = Q30 - x;
        end
        x2   = (x * x) >> 30;
        poly = K9;
        poly = K7 - ((poly * x2) >> 30);
        poly = K5 - ((poly * x2) >> 30);
        poly = K3 - ((poly * x2) >> 30);
        poly = K1 - ((poly * x2) >> 30);
        s    = (poly * x) >> 30;
        if (s > Q30) begin
            s = Q30;
        end
        s = (s + 64'd16384) >> 15;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic logic [CMP_W-1:0] phase_count(input longint twice);
        longint unsigned d, lim, sup;
        if (cfg_supply == 0) begin
            return '0;
        end
        d   = (twice < 0) ? 64'd0 : $unsigned(twice);
        lim = 64'(cfg_limit) << 32;
        sup = 64'(cfg_supply) << 32;
        if (d > lim) begin
            d = lim;
        end
        if (d > sup) begin
            d = sup;
        end
        return CMP_W'((d * 64'(cfg_period) + (sup >> 1)) / sup);
    endfunction

    function automatic t_compares predict_compares(input t_cmd c);
        longint unsigned elec;
        int unsigned idx;
        longint sn, cs, uq, ud, alpha, beta, offs;
        t_compares r;
        elec  = (64'(c.mech_angle) * 64'(cfg_pp)) & ((64'd1 << ANGLE_BITS) - 1);
        idx   = int'(elec >> (ANGLE_BITS - SINE_TABLE_BITS));
        sn    = sine_q15(idx);
        cs    = sine_q15(idx + QUARTER_TURN);
        uq    = longint'(c.volt_q);
        ud    = longint'(c.volt_d);
        alpha = ud * cs - uq * sn;
        beta  = uq * cs + ud * sn;
        offs  = longint'(64'(cfg_supply) << 31);
        r.compare_a = phase_count(alpha * 131072 + offs);
        r.compare_b = phase_count(ROOT3_Q16 * beta - alpha * 65536 + offs);
        r.compare_c = phase_count(-(alpha * 65536) - ROOT3_Q16 * beta + offs);
        return r;
    endfunction

    function automatic logic signed [VOLT_W-1:0] random_volt();
        logic signed [VOLT_W-1:0] v;
        v = VOLT_W'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return v >>> $urandom_range(0, 8);
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        case ($urandom_range(0, 7))
            0: c.mech_angle = 16'($urandom_range(0, 3)) << (ANGLE_BITS - 2);
            1: c.mech_angle = '1;
            default: c.mech_angle = ANGLE_BITS'($urandom);
        endcase
        c.volt_q = random_volt();
        c.volt_d = random_volt();
        return c;
    endfunction

    task automatic queue_cmd(input t_cmd c);
        cmd_backlog.push_back(c);
        awaited_results++;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++) begin
            queue_cmd(random_cmd());
        end
    endtask

    task automatic wait_idle();
        while (awaited_results != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_POLE_CNT: cfg_pp     = value[PP_W-1:0];
            REG_SUPPLY:   cfg_supply = value[SUPPLY_W-1:0];
            REG_LIMIT:    cfg_limit  = value[LIMIT_W-1:0];
            REG_PERIOD:   cfg_period = value[PERIOD_W-1:0];
        endcase
    endtask

    task automatic apply_setting(input logic [PDATA_W-1:0] pp, input logic [PDATA_W-1:0] sup,
                                 input logic [PDATA_W-1:0] lim, input logic [PDATA_W-1:0] per);
        write_reg(REG_POLE_CNT, pp);
        write_reg(REG_SUPPLY, sup);
        write_reg(REG_LIMIT, lim);
        write_reg(REG_PERIOD, per);
    endtask

    // command driver: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd.valid <= 1'b0;
        end else begin
            if (cmd.valid && cmd.ready) begin
                expected_compares.push_back(predict_compares(sent_cmd));
            end
            if (!cmd.valid || cmd.ready) begin
                if (idle_left != 0) begin
                    idle_left--;
                    cmd.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0) begin
                    sent_cmd = cmd_backlog.pop_front();
                    cmd.mech_angle <= sent_cmd.mech_angle;
                    cmd.volt_q     <= sent_cmd.volt_q;
                    cmd.volt_d     <= sent_cmd.volt_d;
                    cmd.valid      <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // compare sink stalls on a rotating 16-bit pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pwm.ready <= 1'b0;
        end else begin
            if (stall_pos == 4'hF) begin
                case ($urandom_range(0, 3))
                    0: stall_pat = '1;
                    1: stall_pat = 16'($urandom);
                    2: stall_pat = 16'($urandom | $urandom);
                    default: stall_pat = 16'($urandom & $urandom);
                endcase
            end
            stall_pos = stall_pos + 4'd1;
            pwm.ready <= stall_pat[stall_pos];
        end
    end

    always @(posedge i_clk) begin
        t_compares exp_beat;
        if (i_rst_n && pwm.valid && pwm.ready) begin
            if (expected_compares.size() == 0) begin
                $error("unexpected compare beat: a=%0d b=%0d c=%0d",
                       pwm.compare_a, pwm.compare_b, pwm.compare_c);
                failures++;
            end else begin
                exp_beat = expected_compares.pop_front();
                awaited_results--;
                if (pwm.compare_a !== exp_beat.compare_a) begin
                    $error("compare_a: expected %0d, got %0d", exp_beat.compare_a, pwm.compare_a);
                    failures++;
                end
                if (pwm.compare_b !== exp_beat.compare_b) begin
                    $error("compare_b: expected %0d, got %0d", exp_beat.compare_b, pwm.compare_b);
                    failures++;
                end
                if (pwm.compare_c !== exp_beat.compare_c) begin
                    $error("compare_c: expected %0d, got %0d", exp_beat.compare_c, pwm.compare_c);
                    failures++;
                end
            end
        end
    end

    initial begin
        cmd.valid      = 1'b0;
        cmd.mech_angle = '0;
        cmd.volt_q     = '0;
        cmd.volt_d     = '0;
        pwm.ready      = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes and a few working points
        queue_cmd('{16'h0000, 16'sh0000, 16'sh0000});
        queue_cmd('{16'hFFFF, 16'sh7FFF, 16'sh8000});
        queue_cmd('{16'h8000, 16'sh8000, 16'sh7FFF});
        queue_cmd('{16'h0000, 16'sh7FFF, 16'sh0000});
        queue_cmd('{16'h0000, 16'sh8000, 16'sh0000});
        queue_cmd('{16'h0000, 16'sh0000, 16'sh7FFF});
        queue_cmd('{16'h0000, 16'sh0000, 16'sh8000});
        queue_cmd('{16'h2492, 16'sh0100, 16'sh0000});
        queue_cmd('{16'h1234, 16'sh0001, 16'shFFFF});
        queue_cmd('{16'h5555, 16'sh0600, 16'sh0300});
        queue_cmd('{16'hAAAA, 16'shFA00, 16'sh0300});
        queue_cmd('{16'h0001, 16'sh0C00, 16'sh0C00});
        queue_cmd('{16'h7FFF, 16'shF400, 16'shF400});
        queue_cmd('{16'h4000, 16'sh0200, 16'shFE00});
        wait_idle();

        apply_setting(64, 16383, 16383, 65535);
        queue_random(12);
        wait_idle();
        apply_setting(1, 1, 1, 1);
        queue_random(12);
        wait_idle();
        // supply written with only bits above its width
        apply_setting(5, 32'hFFFF_C000, 3072, 1280);
        queue_random(12);
        wait_idle();
        apply_setting(3, 3072, 0, 1280);
        queue_random(12);
        wait_idle();
        apply_setting(7, 3072, 3072, 0);
        queue_random(12);
        wait_idle();
        // pole pairs masked down to zero
        apply_setting(32'h0000_0080, 2048, 1024, 5000);
        queue_random(12);
        wait_idle();
        apply_setting(11, 1000, 16383, 40000);
        queue_random(12);
        wait_idle();
        apply_setting(32'hFFFF_FFFF, 32'hABCD_3FFF, 32'h1234_2000, 32'hFFFF_FFFF);
        queue_random(12);
        wait_idle();

        for (int s = 0; s < 10; s++) begin
            apply_setting($urandom_range(0, 127),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 16383),
                          $urandom_range(0, 16383),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
                                                      : $urandom_range(1, 65535));
            queue_random(50);
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
design/fvp_pkg.sv
design/fvp_if.sv
design/fvp_regs.sv
design/fvp_sincos.sv
design/fvp_xform.sv
design/fvp_duty.sv
design/foc_voltage_to_pwm.sv
tb/tb_foc_voltage_to_pwm.sv
